FILE: src/xrs_pkg.sv
// Shared constants, codes and the controller command type of the random source.
`timescale 1ns / 1ps

package xrs_pkg;

	// Word widths.
	localparam int WordW = 64;
	localparam int HalfW = 32;
	localparam int FracW = 53;
	localparam int OutW  = 120;

	// Start words loaded at reset.
	localparam logic [63:0] RESET_WORD0 = 64'h853c49e6748fea9b;
	localparam logic [63:0] RESET_WORD1 = 64'hda3e39cb94b95bdb;

	// Mixing constants of one seed expansion round.
	localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_MUL_B    = 64'h94d049bb133111eb;

	// Partial product selected in one multiplier step.
	localparam logic [1:0] MUL_LL = 2'd0;  // low half by low half, full 64 bits
	localparam logic [1:0] MUL_HL = 2'd1;  // operand high half by constant low half
	localparam logic [1:0] MUL_LH = 2'd2;  // operand low half by constant high half

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       capture_seed;
		logic       draw;
		logic       pre;
		logic       pre_sel_w0;
		logic       mul_en;
		logic [1:0] mul_step;
		logic       mul_const_b;
		logic       mid;
		logic       fin_w0;
		logic       fin_w1;
		logic       load_zero;
	} cmd_t;

endpackage

FILE: src/xrs_datapath.sv
// Datapath of the random source: state words, seed mixer, shared multiplier, result register.
`timescale 1ns / 1ps

module xrs_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  xrs_pkg::cmd_t             cmd,
	input  logic [63:0]               seed,
	output logic [xrs_pkg::OutW-1:0]  result
);

	logic [63:0] state0_q;
	logic [63:0] state1_q;
	logic [63:0] seed_q;
	logic [63:0] x_q;
	logic [63:0] acc_q;
	logic [xrs_pkg::OutW-1:0] result_q;

	logic [63:0] sum;
	logic [63:0] mixed_b;
	logic [63:0] next0;
	logic [63:0] next1;
	logic [63:0] pre_in;
	logic [63:0] pre_sum;
	logic [63:0] pre_mix;
	logic [63:0] mid_mix;
	logic [63:0] fin_val;
	logic [63:0] mul_const;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] prod;

	// Draw: output sum, then the rotate 24, shift 16, rotate 37 advance.
	assign sum     = state0_q + state1_q;
	assign mixed_b = state0_q ^ state1_q;
	assign next0   = {state0_q[39:0], state0_q[63:40]} ^ mixed_b ^ {mixed_b[47:0], 16'd0};
	assign next1   = {mixed_b[26:0], mixed_b[63:27]};

	// Seed expansion steps around the two multiplies.
	assign pre_in  = cmd.pre_sel_w0 ? state0_q : seed_q;
	assign pre_sum = pre_in + xrs_pkg::GOLDEN_GAMMA;
	assign pre_mix = pre_sum ^ {30'd0, pre_sum[63:30]};
	assign mid_mix = acc_q ^ {27'd0, acc_q[63:27]};
	assign fin_val = acc_q ^ {31'd0, acc_q[63:31]};

	// One 32 by 32 multiplier; three steps give the low 64 bits of a 64 by 64 product.
	assign mul_const = cmd.mul_const_b ? xrs_pkg::MIX_MUL_B : xrs_pkg::MIX_MUL_A;
	assign op_a      = (cmd.mul_step == xrs_pkg::MUL_HL) ? x_q[63:32] : x_q[31:0];
	assign op_b      = (cmd.mul_step == xrs_pkg::MUL_LH) ? mul_const[63:32] : mul_const[31:0];
	assign prod      = {32'd0, op_a} * {32'd0, op_b};

	// Generator state words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state0_q <= xrs_pkg::RESET_WORD0;
			state1_q <= xrs_pkg::RESET_WORD1;
		end else if (cmd.draw) begin
			state0_q <= next0;
			state1_q <= next1;
		end else begin
			if (cmd.fin_w0) begin
				state0_q <= fin_val;
			end
			if (cmd.fin_w1) begin
				state1_q <= fin_val;
			end
		end
	end

	// Seed capture, multiplicand and accumulator.
	always_ff @(posedge clk) begin
		if (cmd.capture_seed) begin
			seed_q <= seed;
		end
		if (cmd.pre) begin
			x_q <= pre_mix;
		end else if (cmd.mid) begin
			x_q <= mid_mix;
		end
		if (cmd.mul_en) begin
			if (cmd.mul_step == xrs_pkg::MUL_LL) begin
				acc_q <= prod;
			end else begin
				acc_q[63:32] <= acc_q[63:32] + prod[31:0];
			end
		end
	end

	// Result word: random_value in the low bits, unit_fraction above it.
	always_ff @(posedge clk) begin
		if (cmd.draw) begin
			result_q <= {{(xrs_pkg::OutW - xrs_pkg::WordW - xrs_pkg::FracW){1'b0}},
				sum[63:11], sum};
		end else if (cmd.load_zero) begin
			result_q <= '0;
		end
	end

	assign result = result_q;

endmodule

FILE: src/xrs_ctrl.sv
// Controller of the random source: handshakes and the reseed sequence.
`timescale 1ns / 1ps

module xrs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_action,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output xrs_pkg::cmd_t cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_PRE  = 4'd1;
	localparam logic [3:0] ST_MA0  = 4'd2;
	localparam logic [3:0] ST_MA1  = 4'd3;
	localparam logic [3:0] ST_MA2  = 4'd4;
	localparam logic [3:0] ST_MID  = 4'd5;
	localparam logic [3:0] ST_MB0  = 4'd6;
	localparam logic [3:0] ST_MB1  = 4'd7;
	localparam logic [3:0] ST_MB2  = 4'd8;
	localparam logic [3:0] ST_FIN  = 4'd9;
	localparam logic [3:0] ST_DONE = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       round_q;
	logic       out_valid_q;
	logic       out_free;
	logic       accept;
	logic       load_out;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign accept   = in_valid && in_ready;
	assign load_out = cmd.draw || cmd.load_zero;

	// Next state and commands.
	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		cmd.pre_sel_w0  = round_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_action) begin
						cmd.capture_seed = 1'b1;
						state_d          = ST_PRE;
					end else begin
						cmd.draw = 1'b1;
					end
				end
			end
			ST_PRE: begin
				cmd.pre = 1'b1;
				state_d = ST_MA0;
			end
			ST_MA0: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_step = xrs_pkg::MUL_LL;
				state_d      = ST_MA1;
			end
			ST_MA1: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_step = xrs_pkg::MUL_HL;
				state_d      = ST_MA2;
			end
			ST_MA2: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_step = xrs_pkg::MUL_LH;
				state_d      = ST_MID;
			end
			ST_MID: begin
				cmd.mid = 1'b1;
				state_d = ST_MB0;
			end
			ST_MB0: begin
				cmd.mul_en      = 1'b1;
				cmd.mul_const_b = 1'b1;
				cmd.mul_step    = xrs_pkg::MUL_LL;
				state_d         = ST_MB1;
			end
			ST_MB1: begin
				cmd.mul_en      = 1'b1;
				cmd.mul_const_b = 1'b1;
				cmd.mul_step    = xrs_pkg::MUL_HL;
				state_d         = ST_MB2;
			end
			ST_MB2: begin
				cmd.mul_en      = 1'b1;
				cmd.mul_const_b = 1'b1;
				cmd.mul_step    = xrs_pkg::MUL_LH;
				state_d         = ST_FIN;
			end
			ST_FIN: begin
				if (round_q) begin
					cmd.fin_w1 = 1'b1;
					state_d    = ST_DONE;
				end else begin
					cmd.fin_w0 = 1'b1;
					state_d    = ST_PRE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.load_zero = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State, round flag and output word valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			round_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.capture_seed) begin
				round_q <= 1'b0;
			end else if (cmd.fin_w0) begin
				round_q <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: src/xoroshiro128plus_random_source_unit.sv
// Top level of the xoroshiro128+ random source with splitmix64 reseeding.
`timescale 1ns / 1ps

// The result of an accepted draw word (tuser 0) is loaded into the output register at the
// accepting edge and is offered in the next cycle. Draws stream at one word per cycle while
// the output side keeps taking words. After a reseed word (tuser 1) is accepted, tready
// stays low until the reseed sequence is over. Each of the two chained splitmix64 rounds
// takes nine steps, because every 64-bit multiply is three passes through one shared
// 32 by 32 multiplier. A final step loads the result word, which is all zeros. That
// last step lasts longer while an earlier result still waits on the output
// side. Reset loads the fixed start words.
module xoroshiro128plus_random_source_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [63:0]               s_axis_tdata,  // seed[63:0]
	input  logic [0:0]                s_axis_tuser,  // action[0]: 0 draw, 1 reseed
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// random_value[63:0], unit_fraction[116:64], zeros
	output logic [xrs_pkg::OutW-1:0]  m_axis_tdata
);

	xrs_pkg::cmd_t cmd;

	// Sequencing and handshakes.
	xrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_action (s_axis_tuser[0]),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	// Arithmetic and storage.
	xrs_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.seed   (s_axis_tdata),
		.result (m_axis_tdata)
	);

endmodule

FILE: bench/xoroshiro128plus_random_source_unit_tb.sv
// Self-checking testbench of the xoroshiro128+ random source with splitmix64 reseeding.
`timescale 1ns / 1ps

module xoroshiro128plus_random_source_unit_tb;

	localparam int          CLK_PERIOD    = 4;
	localparam int          RESET_CYCLES  = 4;
	localparam int          RANDOM_WORDS  = 800;
	localparam int          STALL_LIMIT   = 1000;
	localparam int          DRAIN_CYCLES  = 40;
	localparam int          HOLD_CYCLES   = 120;
	localparam int unsigned HOLD_AT_WORD  = 150;
	localparam int          MAX_REPORTS   = 10;

	// Action codes carried in tuser.
	localparam logic ACT_DRAW   = 1'b0;
	localparam logic ACT_RESEED = 1'b1;

	// One expected output word.
	typedef struct packed {
		logic [xrs_pkg::WordW-1:0] value;
		logic [xrs_pkg::FracW-1:0] fraction;
	} rand_word_t;

	// Tracks the generator state and the queue of output words still owed by the block.
	class xrs_scoreboard;
		logic [xrs_pkg::WordW-1:0] st0;
		logic [xrs_pkg::WordW-1:0] st1;
		rand_word_t                expected_words[$];
		int unsigned               mismatches;

		function new();
			st0 = xrs_pkg::RESET_WORD0;
			st1 = xrs_pkg::RESET_WORD1;
			mismatches = 0;
		endfunction

		// One splitmix64 round.
		function logic [xrs_pkg::WordW-1:0] splitmix_mix(logic [xrs_pkg::WordW-1:0] x);
			logic [xrs_pkg::WordW-1:0] z;
			z = x + xrs_pkg::GOLDEN_GAMMA;
			z = (z ^ (z >> 30)) * xrs_pkg::MIX_MUL_A;
			z = (z ^ (z >> 27)) * xrs_pkg::MIX_MUL_B;
			return z ^ (z >> 31);
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		function void flag(string field, logic [xrs_pkg::WordW-1:0] exp_v,
			logic [xrs_pkg::WordW-1:0] got_v);
			mismatches++;
			if (mismatches <= MAX_REPORTS) begin
				$display("%0t: mismatch on %s: expected %h, got %h", $realtime, field, exp_v,
					got_v);
			end
		endfunction

		// Called for every accepted input word: updates the state and queues the result.
		function void note_request(logic act, logic [xrs_pkg::WordW-1:0] seed);
			rand_word_t                w;
			logic [xrs_pkg::WordW-1:0] mixed;
			logic [xrs_pkg::WordW-1:0] a;
			logic [xrs_pkg::WordW-1:0] b;
			if (act == ACT_RESEED) begin
				// Two chained rounds; the reseed itself returns an all-zero word.
				mixed = splitmix_mix(seed);
				st0 = mixed;
				st1 = splitmix_mix(mixed);
				w = '0;
			end else begin
				a = st0;
				b = st1;
				w.value = a + b;
				w.fraction = w.value[xrs_pkg::WordW-1:11];
				b = b ^ a;
				st0 = {a[39:0], a[63:40]} ^ b ^ (b << 16);
				st1 = {b[26:0], b[63:27]};
			end
			expected_words.push_back(w);
		endfunction

		// Called for every accepted output word.
		function void check_word(logic [xrs_pkg::OutW-1:0] data);
			rand_word_t w;
			if (expected_words.size() == 0) begin
				flag("unexpected word", '0, data[xrs_pkg::WordW-1:0]);
				return;
			end
			w = expected_words.pop_front();
			if (data[xrs_pkg::WordW-1:0] !== w.value)
				flag("random_value", w.value, data[xrs_pkg::WordW-1:0]);
			if (data[xrs_pkg::WordW+xrs_pkg::FracW-1:xrs_pkg::WordW] !== w.fraction)
				flag("unit_fraction", xrs_pkg::WordW'(w.fraction),
					xrs_pkg::WordW'(data[xrs_pkg::WordW+xrs_pkg::FracW-1:xrs_pkg::WordW]));
			if (data[xrs_pkg::OutW-1:xrs_pkg::WordW+xrs_pkg::FracW] !== '0)
				flag("pad bits", '0,
					xrs_pkg::WordW'(data[xrs_pkg::OutW-1:xrs_pkg::WordW+xrs_pkg::FracW]));
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     s_axis_tvalid;
	logic                     s_axis_tready;
	logic [63:0]              s_axis_tdata;   // seed[63:0]
	logic [0:0]               s_axis_tuser;   // action[0]
	logic                     m_axis_tvalid;
	logic                     m_axis_tready;
	// random_value[63:0], unit_fraction[116:64], zeros
	logic [xrs_pkg::OutW-1:0] m_axis_tdata;

	logic            tx_idle_on;
	logic            rx_idle_on;
	int unsigned     words_seen = 0;
	xrs_scoreboard   sb = new();

	xoroshiro128plus_random_source_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Offers one word, with random gaps ahead of it, and waits until the block takes it.
	task automatic send_word(input logic act, input logic [63:0] seed);
		if (tx_idle_on) begin
			while ($urandom_range(99) < 11) begin
				// Junk on the data lines while valid is low must be ignored.
				s_axis_tvalid <= 1'b0;
				s_axis_tdata <= {$urandom, $urandom};
				s_axis_tuser <= 1'($urandom_range(1));
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= seed;
		s_axis_tuser <= act;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_request(act, seed);
	endtask

	// Seeds lean toward the extremes and one-hot values, the rest fully random.
	function automatic logic [63:0] pick_seed();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return 64'd1 << $urandom_range(63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Output side: random back-pressure plus one long hold-off that fills the block.
	initial begin : sink
		int unsigned hold;
		bit          hold_done;
		hold = 0;
		hold_done = 1'b0;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (words_seen == HOLD_AT_WORD && !hold_done) begin
				hold_done = 1'b1;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= !(rx_idle_on && $urandom_range(99) < 11);
			end
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_word(m_axis_tdata);
				words_seen++;
			end
		end
	end

	// Ends the run if neither side moves a word for too long.
	initial begin : watchdog
		int stall_cycles;
		stall_cycles = 0;
		wait (arst_n === 1'b1);
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("xoroshiro128plus_random_source_unit_tb failed");
		$finish;
	end

	// Reset, directed words, random words, then drain and report.
	initial begin : stimulus
		int   n;
		logic act;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = ACT_DRAW;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Draws from the start words; the seed lines must not matter on a draw.
		send_word(ACT_DRAW, '0);
		send_word(ACT_DRAW, '1);
		send_word(ACT_DRAW, {$urandom, $urandom});
		send_word(ACT_DRAW, 64'h5555_5555_5555_5555);
		// Reseeds with extreme seeds, each followed by draws.
		send_word(ACT_RESEED, '0);
		send_word(ACT_DRAW, '1);
		send_word(ACT_DRAW, '0);
		send_word(ACT_RESEED, '1);
		send_word(ACT_DRAW, '0);
		send_word(ACT_RESEED, 64'h8000_0000_0000_0000);
		send_word(ACT_DRAW, 64'hAAAA_AAAA_AAAA_AAAA);
		send_word(ACT_RESEED, 64'h1);
		send_word(ACT_DRAW, '0);
		send_word(ACT_DRAW, '0);
		// Back-to-back reseeds: only the second one may count.
		send_word(ACT_RESEED, 64'h0123_4567_89AB_CDEF);
		send_word(ACT_RESEED, 64'hFEDC_BA98_7654_3210);
		send_word(ACT_DRAW, '1);
		send_word(ACT_DRAW, '0);
		send_word(ACT_RESEED, 64'h7FFF_FFFF_FFFF_FFFF);
		send_word(ACT_DRAW, '0);

		// Mostly draws, with an occasional reseed; a stretch in the middle runs without gaps.
		for (n = 0; n < RANDOM_WORDS; n++) begin
			tx_idle_on = !(n >= 300 && n < 450);
			rx_idle_on = tx_idle_on;
			act = ($urandom_range(99) < 6) ? ACT_RESEED : ACT_DRAW;
			send_word(act, pick_seed());
		end
		s_axis_tvalid <= 1'b0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("xoroshiro128plus_random_source_unit_tb passed");
		else
			$display("xoroshiro128plus_random_source_unit_tb failed");
		$finish;
	end

endmodule
